[design/jfdd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package jfdd_pkg;

   // Frame geometry and queue sizing.
   localparam int DATA_BYTES_DEFAULT  = 6;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Sync sequence that opens a frame.
   localparam logic [7:0] SYNC_FIRST  = 8'h00;
   localparam logic [7:0] SYNC_SECOND = 8'hFF;

   // Joystick center value.
   localparam logic [7:0] CENTER = 8'h80;

   // Duty clamp: magnitudes of DUTY_LIMIT and above become DUTY_MAX.
   localparam logic [8:0] DUTY_LIMIT = 9'd100;
   localparam logic [6:0] DUTY_MAX   = 7'd99;

   // The vertical gain of 1.2 is 6/5. The divide by 5 is a multiply by 205 and a
   // right shift by 10, which is exact for every product up to 1023 (at most 768 here).
   localparam int          DY_PROD_W = 18;
   localparam logic [10:0] DY_SCALE  = 11'd1230;
   localparam int          DY_SHIFT  = 10;

   // The horizontal gain of 0.75 is three quarters.
   localparam logic [9:0]  DX_SCALE  = 10'd3;
   localparam int          DX_SHIFT  = 2;

   // One finished frame as seen by the mixing side.
   typedef struct packed {
      logic       ok;
      logic [7:0] joy_x;
      logic [7:0] joy_y;
   } frame_word_type;

   // Scaled joystick offsets after the first mixing stage.
   typedef struct packed {
      logic              ok;
      logic [7:0]        joy_x;
      logic [7:0]        joy_y;
      logic signed [8:0] dy;
      logic signed [8:0] dx;
   } mix_stage_type;

   // Absolute value of a joystick byte around the center.
   function automatic logic [7:0] center_magnitude(input logic [7:0] value);
      logic [7:0] result;
      if (value < CENTER) begin
         result = CENTER - value;
      end else begin
         result = value - CENTER;
      end
      return result;
   endfunction

   // Duty for one motor: absolute value of the command, clamped.
   function automatic logic [6:0] duty_of(input logic signed [8:0] speed);
      logic [8:0] mag;
      logic [6:0] result;
      mag = speed[8] ? 9'(-speed) : 9'(speed);
      if (mag >= DUTY_LIMIT) begin
         result = DUTY_MAX;
      end else begin
         result = mag[6:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[design/jfdd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module jfdd_front #(
   parameter int DATA_BYTES = jfdd_pkg::DATA_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_valid,
   input  logic [7:0]               rx_byte,
   output logic                     word_valid,
   output jfdd_pkg::frame_word_type word
);
   import jfdd_pkg::*;

   localparam int PosW = $clog2(DATA_BYTES + 1);

   logic [7:0]      prev_ff, prev_in;
   logic            in_frame_ff, in_frame_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [7:0]      sum_ff, sum_in;
   logic [7:0]      x_ff, x_in;
   logic [7:0]      y_ff, y_in;

   // The running sum replaces the stored data bytes; only X and Y are kept.
   always_comb begin
      prev_in     = prev_ff;
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      word_valid  = 1'b0;
      word.ok     = (sum_ff == rx_byte);
      word.joy_x  = x_ff;
      word.joy_y  = y_ff;
      if (byte_valid) begin
         prev_in = rx_byte;
         if ((prev_ff == SYNC_FIRST) && (rx_byte == SYNC_SECOND)) begin
            in_frame_in = 1'b1;
            pos_in      = '0;
            sum_in      = '0;
         end else if (in_frame_ff) begin
            if (pos_ff < PosW'(DATA_BYTES)) begin
               if (pos_ff == PosW'(0)) begin
                  x_in = rx_byte;
               end
               if (pos_ff == PosW'(1)) begin
                  y_in = rx_byte;
               end
               sum_in = sum_ff + rx_byte;
               pos_in = pos_ff + PosW'(1);
            end else begin
               word_valid  = 1'b1;
               in_frame_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= SYNC_FIRST;
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         prev_ff     <= prev_in;
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
      end
      sum_ff <= sum_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

endmodule

`default_nettype wire

[design/jfdd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module jfdd_queue #(
   parameter int DEPTH = jfdd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  jfdd_pkg::frame_word_type push_word,
   output logic                     full,
   input  logic                     pop,
   output logic                     valid,
   output jfdd_pkg::frame_word_type pop_word
);
   import jfdd_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   frame_word_type  slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_word = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

[design/jfdd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module jfdd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     word_valid,
   input  jfdd_pkg::frame_word_type word,
   output logic                     word_pop,
   input  logic                     pop,
   output logic                     empty,
   output logic                     rsp_frame_ok,
   output logic [7:0]               rsp_joy_x,
   output logic [7:0]               rsp_joy_y,
   output logic signed [8:0]        rsp_speed_a,
   output logic signed [8:0]        rsp_speed_b,
   output logic [6:0]               rsp_duty_a,
   output logic                     rsp_forward_a,
   output logic [6:0]               rsp_duty_b,
   output logic                     rsp_forward_b
);
   import jfdd_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   mix_stage_type s1_ff, s1_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_ready;
   logic          s1_ready;

   logic [7:0]           x_mag;
   logic [7:0]           y_mag;
   logic [9:0]           dx_prod;
   logic [DY_PROD_W-1:0] dy_prod;
   logic [7:0]           dx_mag;
   logic [7:0]           dy_mag;

   logic signed [8:0] speed_a;
   logic signed [8:0] speed_b;

   logic              ok_ff;
   logic [7:0]        joy_x_ff, joy_y_ff;
   logic signed [8:0] speed_a_ff, speed_b_ff;
   logic [6:0]        duty_a_ff, duty_b_ff;
   logic              forward_a_ff, forward_b_ff;

   assign out_ready = !out_valid_ff || pop;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign word_pop  = word_valid && s1_ready;

   // First stage: scale the centered joystick values by 1.2 and 0.75, truncating
   // toward zero by working on magnitudes.
   always_comb begin
      x_mag   = center_magnitude(word.joy_x);
      y_mag   = center_magnitude(word.joy_y);
      dx_prod = 10'(x_mag) * DX_SCALE;
      dy_prod = DY_PROD_W'(y_mag) * DY_PROD_W'(DY_SCALE);
      dx_mag  = 8'(dx_prod >> DX_SHIFT);
      dy_mag  = 8'(dy_prod >> DY_SHIFT);
      s1_in.ok    = word.ok;
      s1_in.joy_x = word.joy_x;
      s1_in.joy_y = word.joy_y;
      s1_in.dx    = (word.joy_x < CENTER) ? -$signed({1'b0, dx_mag})
                                           : $signed({1'b0, dx_mag});
      s1_in.dy    = (word.joy_y < CENTER) ? -$signed({1'b0, dy_mag})
                                           : $signed({1'b0, dy_mag});
      s1_valid_in = s1_ready ? word_valid : s1_valid_ff;
   end

   // Second stage: tank-drive mix into the result register.
   assign speed_a      = s1_ff.dy - s1_ff.dx;
   assign speed_b      = s1_ff.dy + s1_ff.dx;
   assign out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (out_ready) begin
         ok_ff <= s1_ff.ok;
         if (s1_ff.ok) begin
            joy_x_ff     <= s1_ff.joy_x;
            joy_y_ff     <= s1_ff.joy_y;
            speed_a_ff   <= speed_a;
            speed_b_ff   <= speed_b;
            duty_a_ff    <= duty_of(speed_a);
            duty_b_ff    <= duty_of(speed_b);
            forward_a_ff <= !speed_a[8];
            forward_b_ff <= !speed_b[8];
         end else begin
            joy_x_ff     <= '0;
            joy_y_ff     <= '0;
            speed_a_ff   <= '0;
            speed_b_ff   <= '0;
            duty_a_ff    <= '0;
            duty_b_ff    <= '0;
            forward_a_ff <= 1'b0;
            forward_b_ff <= 1'b0;
         end
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_frame_ok  = ok_ff;
   assign rsp_joy_x     = joy_x_ff;
   assign rsp_joy_y     = joy_y_ff;
   assign rsp_speed_a   = speed_a_ff;
   assign rsp_speed_b   = speed_b_ff;
   assign rsp_duty_a    = duty_a_ff;
   assign rsp_forward_a = forward_a_ff;
   assign rsp_duty_b    = duty_b_ff;
   assign rsp_forward_b = forward_b_ff;

endmodule

`default_nettype wire

[design/joystick_frame_to_differential_drive_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Joystick frame deframer with tank-drive mixing. Received bytes are pushed one
// word per cycle; a frame opens on the byte pair 0x00, 0xFF (recognized on every
// byte, also inside a frame, where it restarts the frame), then carries DATA_BYTES
// data bytes and a check byte equal to their sum modulo 256. Each check byte
// produces exactly one result word: on a match, frame_ok is set and data bytes 0
// and 1 (X and Y) are mixed into two signed motor commands A = dy - dx and
// B = dy + dx, with dy = (Y - 128) * 1.2 and dx = (X - 128) * 0.75 truncated toward
// zero, plus a direction bit and a duty of the magnitude clamped to 99 for each;
// on a mismatch frame_ok is clear and every other field is zero. The byte path
// accepts one word every cycle while full is low. On its way out a result word
// is registered in turn: the deframer writes a frame word into a queue of
// QUEUE_DEPTH entries, one stage scales the joystick values and the result
// register holds the mixed commands. full rises only when QUEUE_DEPTH frame
// results are waiting behind a stalled result side; since a result needs at
// least DATA_BYTES + 3 bytes, a consumer that pops now and then never stalls the
// byte stream.
module joystick_frame_to_differential_drive_core #(
   parameter int DATA_BYTES  = jfdd_pkg::DATA_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = jfdd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        req_rx_byte,
   output logic              empty,
   input  logic              pop,
   output logic              rsp_frame_ok,
   output logic [7:0]        rsp_joy_x,
   output logic [7:0]        rsp_joy_y,
   output logic signed [8:0] rsp_speed_a,
   output logic signed [8:0] rsp_speed_b,
   output logic [6:0]        rsp_duty_a,
   output logic              rsp_forward_a,
   output logic [6:0]        rsp_duty_b,
   output logic              rsp_forward_b
);
   import jfdd_pkg::*;

   logic           byte_valid;
   logic           front_word_valid;
   frame_word_type front_word;
   logic           queue_valid;
   frame_word_type queue_word;
   logic           queue_pop;

   // A byte is taken whenever there is room for the result it might complete.
   assign byte_valid = push && !full;

   jfdd_front #(
      .DATA_BYTES(DATA_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .word_valid (front_word_valid),
      .word       (front_word)
   );

   jfdd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_word_valid),
      .push_word (front_word),
      .full      (full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .pop_word  (queue_word)
   );

   jfdd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .word_valid    (queue_valid),
      .word          (queue_word),
      .word_pop      (queue_pop),
      .pop           (pop),
      .empty         (empty),
      .rsp_frame_ok  (rsp_frame_ok),
      .rsp_joy_x     (rsp_joy_x),
      .rsp_joy_y     (rsp_joy_y),
      .rsp_speed_a   (rsp_speed_a),
      .rsp_speed_b   (rsp_speed_b),
      .rsp_duty_a    (rsp_duty_a),
      .rsp_forward_a (rsp_forward_a),
      .rsp_duty_b    (rsp_duty_b),
      .rsp_forward_b (rsp_forward_b)
   );

endmodule

`default_nettype wire

[design/jfdd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module jfdd_checker (
   input logic              clock,
   input logic              reset,
   input logic              push,
   input logic              full,
   input logic [7:0]        req_rx_byte,
   input logic              empty,
   input logic              pop,
   input logic              rsp_frame_ok,
   input logic [7:0]        rsp_joy_x,
   input logic [7:0]        rsp_joy_y,
   input logic signed [8:0] rsp_speed_a,
   input logic signed [8:0] rsp_speed_b,
   input logic [6:0]        rsp_duty_a,
   input logic              rsp_forward_a,
   input logic [6:0]        rsp_duty_b,
   input logic              rsp_forward_b
);

   // The result side comes out of reset with nothing waiting.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result word present right after reset");

   // A waiting result word that is not popped stays in place, its flag, joystick bytes and motor commands unchanged.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_frame_ok) && $stable(rsp_joy_x)
         && $stable(rsp_joy_y) && $stable(rsp_speed_a) && $stable(rsp_speed_b)))
      else $error("waiting result word changed before it was popped");

   // A failed check byte carries nothing but the error flag.
   a_mismatch_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_frame_ok) |-> (rsp_joy_x == 8'd0 && rsp_joy_y == 8'd0
         && rsp_speed_a == 9'sd0 && rsp_speed_b == 9'sd0 && rsp_duty_a == 7'd0
         && rsp_duty_b == 7'd0 && !rsp_forward_a && !rsp_forward_b))
      else $error("mismatch result carries nonzero fields");

   // Direction and duty follow the signed commands of a good frame.
   a_drive_consistent: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_frame_ok) |-> (rsp_forward_a == !rsp_speed_a[8]
         && rsp_forward_b == !rsp_speed_b[8] && rsp_duty_a <= 7'd99
         && rsp_duty_b <= 7'd99))
      else $error("direction or duty inconsistent with motor command");

endmodule

bind joystick_frame_to_differential_drive_core jfdd_checker u_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the joystick deframer and tank-drive mixer. Bytes go in
// through a queue-style push port. Each accepted byte is run through a local model
// of the deframer, which queues the result word that the block must later produce.
// Result words popped from the block are compared field by field against the
// oldest queued word.
module tb_top;
   import jfdd_pkg::*;

   // Frame geometry and mixing gains. The gains are 1.2 and 0.75 written as
   // exact ratios.
   localparam int NUM_DATA = DATA_BYTES_DEFAULT;
   localparam int DY_NUM   = 12;
   localparam int DY_DEN   = 10;
   localparam int DX_NUM   = 3;
   localparam int DX_DEN   = 4;

   // Run shape.
   localparam int RANDOM_BYTES    = 1350;
   localparam int MAX_REPORTS     = 10;
   localparam int HOLD_OFF_AFTER  = 300;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 12;

   // One result word, laid out in the order of the result ports.
   typedef struct packed {
      logic              ok;
      logic [7:0]        joy_x;
      logic [7:0]        joy_y;
      logic signed [8:0] speed_a;
      logic signed [8:0] speed_b;
      logic [6:0]        duty_a;
      logic              forward_a;
      logic [6:0]        duty_b;
      logic              forward_b;
   } drive_word_type;

   // One byte to send. When typed is set, the row carries its own expected word,
   // which replaces whatever the model computes for that byte.
   typedef struct packed {
      logic [7:0]     value;
      logic           typed;
      drive_word_type word;
   } stim_row_type;

   // The receiver switches between these pop behaviors.
   typedef enum int {
      POP_ALWAYS,
      POP_PATTERN,
      POP_SPARSE
   } pop_mode_type;

   // A failed check byte clears every field. Full deflection (X and Y both 0xFF)
   // gives dy = 152 and dx = 95, so A = 57 and B = 247, the latter clamped to 99.
   localparam drive_word_type IDLE_WORD    = '0;
   localparam drive_word_type CHECK_FAIL   = '0;
   localparam drive_word_type FULL_DEFLECT = {1'b1, 8'hFF, 8'hFF, 9'sd57, 9'sd247,
                                              7'd57, 1'b1, 7'd99, 1'b1};

   // Directed opening: a byte outside any frame, a frame restarted by a sync that
   // lands on its data bytes, a full-deflection frame with a good check byte, and
   // a frame whose check byte does not match.
   stim_row_type directed_rows [0:21] = '{
      {8'h55,       1'b0, IDLE_WORD},
      {SYNC_FIRST,  1'b0, IDLE_WORD},
      {SYNC_SECOND, 1'b0, IDLE_WORD},
      {8'h3C,       1'b0, IDLE_WORD},
      {SYNC_FIRST,  1'b0, IDLE_WORD},
      {SYNC_SECOND, 1'b0, IDLE_WORD},
      {8'hFF,       1'b0, IDLE_WORD},
      {8'hFF,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'hFE,       1'b1, FULL_DEFLECT},
      {SYNC_FIRST,  1'b0, IDLE_WORD},
      {SYNC_SECOND, 1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h00,       1'b0, IDLE_WORD},
      {8'h01,       1'b1, CHECK_FAIL}
   };

   // Clock, reset and block inputs, all known from time zero.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        push        = 1'b0;
   logic        pop         = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;

   logic              full;
   logic              empty;
   logic              rsp_frame_ok;
   logic [7:0]        rsp_joy_x;
   logic [7:0]        rsp_joy_y;
   logic signed [8:0] rsp_speed_a;
   logic signed [8:0] rsp_speed_b;
   logic [6:0]        rsp_duty_a;
   logic              rsp_forward_a;
   logic [6:0]        rsp_duty_b;
   logic              rsp_forward_b;

   // The byte stream to send, and the result words still owed by the block.
   stim_row_type   rx_stream [$];
   drive_word_type drive_words_due [$];
   int             accepted_count = 0;
   int             mismatch_count = 0;

   // Local copy of the deframer state.
   logic [7:0] frame_prev_byte = 8'h00;
   logic       frame_open      = 1'b0;
   int         frame_fill      = 0;
   logic [7:0] frame_data [NUM_DATA];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   joystick_frame_to_differential_drive_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_rx_byte   (req_rx_byte),
      .empty         (empty),
      .pop           (pop),
      .rsp_frame_ok  (rsp_frame_ok),
      .rsp_joy_x     (rsp_joy_x),
      .rsp_joy_y     (rsp_joy_y),
      .rsp_speed_a   (rsp_speed_a),
      .rsp_speed_b   (rsp_speed_b),
      .rsp_duty_a    (rsp_duty_a),
      .rsp_forward_a (rsp_forward_a),
      .rsp_duty_b    (rsp_duty_b),
      .rsp_forward_b (rsp_forward_b)
   );

   // Magnitude of a motor command, clamped to the largest duty.
   function automatic logic [6:0] clamp_duty(input int speed);
      int mag;
      mag = (speed < 0) ? -speed : speed;
      return (mag >= int'(DUTY_LIMIT)) ? DUTY_MAX : 7'(mag);
   endfunction

   // Advances the local deframer by one byte. Returns 1 when the byte is a check
   // byte, in which case word holds the result word the block must produce.
   function automatic logic mix_frame_byte(input logic [7:0] rx,
                                           output drive_word_type word);
      logic       sync_seen;
      logic [7:0] sum;
      int         x;
      int         y;
      int         dy;
      int         dx;
      int         a;
      int         b;
      int         i;
      word = '0;
      sync_seen = (frame_prev_byte == SYNC_FIRST) && (rx == SYNC_SECOND);
      frame_prev_byte = rx;
      // A completed sync always opens a fresh frame, even in the middle of one.
      if (sync_seen) begin
         frame_open = 1'b1;
         frame_fill = 0;
         return 1'b0;
      end
      if (!frame_open) begin
         return 1'b0;
      end
      if (frame_fill < NUM_DATA) begin
         frame_data[frame_fill] = rx;
         frame_fill++;
         return 1'b0;
      end
      // This is the check byte.
      sum = '0;
      for (i = 0; i < NUM_DATA; i++) begin
         sum = sum + frame_data[i];
      end
      frame_open = 1'b0;
      if (sum != rx) begin
         return 1'b1;
      end
      // Integer division truncates toward zero, as the mix requires.
      x  = int'(frame_data[0]);
      y  = int'(frame_data[1]);
      dy = ((y - int'(CENTER)) * DY_NUM) / DY_DEN;
      dx = ((x - int'(CENTER)) * DX_NUM) / DX_DEN;
      a  = dy - dx;
      b  = dy + dx;
      word.ok        = 1'b1;
      word.joy_x     = frame_data[0];
      word.joy_y     = frame_data[1];
      word.speed_a   = 9'(a);
      word.speed_b   = 9'(b);
      word.duty_a    = clamp_duty(a);
      word.forward_a = (a >= 0);
      word.duty_b    = clamp_duty(b);
      word.forward_b = (b >= 0);
      return 1'b1;
   endfunction

   // Random byte with extra weight on the sync bytes (also the joystick extremes) and the values around the center.
   function automatic logic [7:0] pick_data_byte();
      logic [7:0] value;
      value = 8'($urandom);
      if ($urandom_range(0, 5) == 0) begin
         case ($urandom_range(0, 4))
            0: value = SYNC_FIRST;
            1: value = SYNC_SECOND;
            2: value = CENTER - 8'd1;
            3: value = CENTER;
            default: value = CENTER + 8'd1;
         endcase
      end
      return value;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned seen);
      if (want != seen) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name,
                     want, seen);
         end
      end
   endfunction

   // Everything is sampled at the rising edge, where the inputs driven at the
   // falling edge are settled and the block's outputs still show the values from
   // before the edge. A result word passes the queue, scaling and result registers,
   // so comparing before predicting never skips a word.
   always @(posedge clock) begin
      drive_word_type seen;
      drive_word_type want;
      drive_word_type predicted;
      logic           has_word;
      if (!reset) begin
         if (pop && !empty) begin
            seen = {rsp_frame_ok, rsp_joy_x, rsp_joy_y, rsp_speed_a, rsp_speed_b,
                    rsp_duty_a, rsp_forward_a, rsp_duty_b, rsp_forward_b};
            if (drive_words_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: result word 0x%0h arrived with none expected",
                           $realtime, seen);
               end
            end else begin
               want = drive_words_due.pop_front();
               check_field("frame_ok",  want.ok,        seen.ok);
               check_field("joy_x",     want.joy_x,     seen.joy_x);
               check_field("joy_y",     want.joy_y,     seen.joy_y);
               check_field("speed_a",   want.speed_a,   seen.speed_a);
               check_field("speed_b",   want.speed_b,   seen.speed_b);
               check_field("duty_a",    want.duty_a,    seen.duty_a);
               check_field("forward_a", want.forward_a, seen.forward_a);
               check_field("duty_b",    want.duty_b,    seen.duty_b);
               check_field("forward_b", want.forward_b, seen.forward_b);
            end
         end
         // The model always advances, so typed rows keep its state in step too.
         if (push && !full) begin
            has_word = mix_frame_byte(rx_stream[accepted_count].value, predicted);
            if (rx_stream[accepted_count].typed) begin
               drive_words_due.push_back(rx_stream[accepted_count].word);
            end else if (has_word) begin
               drive_words_due.push_back(predicted);
            end
            accepted_count++;
         end
      end
   end

   // Sender. Bytes go out in bursts of random length separated by random gaps,
   // and a third of the bursts run straight into the next one. A byte stays on the
   // port until the monitor counts it as accepted; push is written once per step.
   initial begin : sender
      int   burst_left;
      int   gap_left;
      int   next_idx;
      int   offer_idx;
      logic offering;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
      next_idx   = 0;
      offer_idx  = 0;
      offering   = 1'b0;
      wait (!reset);
      while (accepted_count < rx_stream.size()) begin
         @(negedge clock);
         if (offering && accepted_count > offer_idx) begin
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               push <= 1'b0;
               gap_left--;
            end else if (next_idx < rx_stream.size()) begin
               push        <= 1'b1;
               req_rx_byte <= rx_stream[next_idx].value;
               offer_idx    = next_idx;
               next_idx++;
               offering     = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // Receiver. It switches its pop behavior at random: pop on every cycle, follow
   // a random 16-bit pattern, or pop only now and then. Once, after HOLD_OFF_AFTER
   // accepted bytes, it stops popping while the sender keeps going, so the result
   // queue fills and full holds off the byte stream.
   initial begin : receiver
      pop_mode_type mode;
      int           mode_left;
      int           hold_left;
      int           phase;
      logic         hold_done;
      logic [15:0]  pattern;
      mode      = POP_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      hold_done = 1'b0;
      pattern   = '0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && accepted_count >= HOLD_OFF_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = pop_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 80);
            pattern   = 16'($urandom);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            case (mode)
               POP_ALWAYS: pop <= 1'b1;
               POP_PATTERN: begin
                  pop  <= pattern[phase];
                  phase = (phase + 1) % 16;
               end
               default: pop <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Main sequence. The directed table goes first, then the random stream: most
   // of it is well-formed frames with random content, where one check byte in ten
   // is off by a bit and one in ten is random. The rest is cut-off frames, which
   // the next sync restarts, and runs of noise.
   initial begin : main_sequence
      int         kind;
      int         count;
      int         i;
      logic [7:0] sum;
      logic [7:0] value;
      foreach (directed_rows[row]) begin
         rx_stream.push_back(directed_rows[row]);
      end
      while (rx_stream.size() < $size(directed_rows) + RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            rx_stream.push_back({SYNC_FIRST, 1'b0, IDLE_WORD});
            rx_stream.push_back({SYNC_SECOND, 1'b0, IDLE_WORD});
            sum = '0;
            for (i = 0; i < NUM_DATA; i++) begin
               value = pick_data_byte();
               sum   = sum + value;
               rx_stream.push_back({value, 1'b0, IDLE_WORD});
            end
            case ($urandom_range(0, 9))
               0: sum = sum ^ (8'd1 << $urandom_range(0, 7));
               1: sum = 8'($urandom);
               default: ;
            endcase
            rx_stream.push_back({sum, 1'b0, IDLE_WORD});
         end else if (kind < 85) begin
            rx_stream.push_back({SYNC_FIRST, 1'b0, IDLE_WORD});
            rx_stream.push_back({SYNC_SECOND, 1'b0, IDLE_WORD});
            count = $urandom_range(0, NUM_DATA);
            for (i = 0; i < count; i++) begin
               rx_stream.push_back({pick_data_byte(), 1'b0, IDLE_WORD});
            end
         end else begin
            count = $urandom_range(1, 8);
            for (i = 0; i < count; i++) begin
               rx_stream.push_back({pick_data_byte(), 1'b0, IDLE_WORD});
            end
         end
      end

      // Synchronous reset, released at a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken and every owed word to come out, then keep
      // the clock running so that the pipeline can show any stray word.
      while (accepted_count < rx_stream.size()) @(posedge clock);
      while (drive_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && drive_words_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[joystick_frame_to_differential_drive_core.f]
design/jfdd_pkg.sv
design/jfdd_front.sv
design/jfdd_queue.sv
design/jfdd_back.sv
design/joystick_frame_to_differential_drive_core.sv
design/jfdd_checker.sv
tb/tb_top.sv
